>>> src/erm_pkg.sv
`timescale 1ns / 1ps
package erm_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int Q = 30;
  localparam int SHW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam int ZW = 33;
  localparam int DEG_FULL = 23040;
  localparam int DEG_QUARTER = 5760;
  localparam int ANGLE_UP = 18;
  localparam logic signed [31:0] INV_GAIN = 32'sd652032874;
  localparam longint RAD_TO_DEG_Q24 = 64'sd961263669;
  localparam int RSH = Q - OUT_FRAC_BITS;
  localparam int NLANES = 3;

  typedef struct packed {
    logic signed [31:0]   x;
    logic signed [31:0]   y;
    logic signed [ZW-1:0] z;
    logic [1:0]           quad;
  } cordic_t;

  typedef cordic_t [NLANES-1:0] lanes_t;

  // atan(2^-i) in units of 2^-24 degree
  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    longint kk, t1, t3, t5, t7, s;
    kk = RAD_TO_DEG_Q24 <<< 20;
    t1 = 0;
    t3 = 0;
    t5 = 0;
    t7 = 0;
    s = 0;
    case (i)
      0: s = 64'sd754974720;
      1: s = 64'sd445687602;
      2: s = 64'sd235489088;
      3: s = 64'sd119537938;
      default: begin
        if (i < 60) t1 = kk >>> i;
        if (3 * i < 60) t3 = (kk >>> (3 * i)) / 3;
        if (5 * i < 60) t5 = (kk >>> (5 * i)) / 5;
        if (7 * i < 60) t7 = (kk >>> (7 * i)) / 7;
        s = (t1 - t3 + t5 - t7 + (64'sd1 <<< 19)) >>> 20;
      end
    endcase
    return ZW'(s);
  endfunction

  // Q2.30 product, round half up
  function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + (64'sd1 <<< (Q - 1));
    return p[Q+31:Q];
  endfunction

  // round to output fraction bits, clamp to +-1, keep the low 16 bits
  function automatic logic [15:0] narrow(input logic signed [32:0] v);
    logic signed [34:0] t;
    logic signed [34:0] one;
    one = 35'sd1 <<< OUT_FRAC_BITS;
    t = 35'(v);
    if (RSH > 0) t = (t + (35'sd1 <<< (RSH - 1))) >>> RSH;
    if (t > one) t = one;
    if (t < -one) t = -one;
    return t[15:0];
  endfunction

endpackage

>>> src/erm_in_if.sv
`timescale 1ns / 1ps
interface erm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_deg;
  logic signed [15:0] pitch_deg;
  logic signed [15:0] heading_deg;

  modport source (output valid, roll_deg, pitch_deg, heading_deg, input ready);
  modport sink (input valid, roll_deg, pitch_deg, heading_deg, output ready);
endinterface

>>> src/erm_out_if.sv
`timescale 1ns / 1ps
interface erm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00;
  logic signed [15:0] m01;
  logic signed [15:0] m02;
  logic signed [15:0] m10;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m20;
  logic signed [15:0] m21;
  logic signed [15:0] m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

>>> src/euler_rotation_matrix_top.sv
`timescale 1ns / 1ps
// Roll-pitch-heading rotation matrix.
//
// in_i carries one transaction per angle triple: roll_deg, pitch_deg and
// heading_deg, signed degrees with six fraction bits. out_o carries one
// transaction per triple with the nine 3x3 matrix elements m00..m22
// in signed Q2.14, in the order the triples came in.
//
// From input transaction to output valid, a triple passes the angle reduction
// register, one cell per CORDIC stage (16) and the quadrant mapping, product,
// sum and rounding registers; the last is the output register. One triple is
// taken per cycle while the receiver does not stall the output; the cell
// chain advances all three angles together in every cell.
//
// The whole pipeline moves as one: it advances whenever the output register
// is empty or being taken. While the receiver stalls with a result waiting,
// in_i.ready drops and every stage holds. Reset empties the pipeline; no
// memory needs clearing, so the block takes input right after reset.
module euler_rotation_matrix_top import erm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  erm_in_if.sink    in_i,
  erm_out_if.source out_o
);

  logic               adv;
  logic signed [15:0] ang [NLANES];
  logic               chain_vld [CORDIC_STAGES+1];
  lanes_t             chain [CORDIC_STAGES+1];
  logic               mat_vld;
  logic [15:0]        mat_m [9];

  // advance when the output slot is free or drains this cycle
  assign adv = !mat_vld || out_o.ready;
  assign in_i.ready = adv;

  assign ang[0] = in_i.roll_deg;
  assign ang[1] = in_i.pitch_deg;
  assign ang[2] = in_i.heading_deg;

  // reduce each angle to a quadrant and a remainder below 90 degrees
  erm_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_i.valid),
    .ang_i   (ang),
    .valid_o (chain_vld[0]),
    .lanes_o (chain[0])
  );

  // one cell per CORDIC iteration, each with its own shift and arctangent
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    erm_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (chain_vld[i]),
      .shamt_i (SHW'(i)),
      .atan_i  (atan_deg(i)),
      .lanes_i (chain[i]),
      .valid_o (chain_vld[i+1]),
      .lanes_o (chain[i+1])
    );
  end

  // place sine and cosine, multiply out the matrix, round into Q2.14
  erm_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (chain_vld[CORDIC_STAGES]),
    .lanes_i (chain[CORDIC_STAGES]),
    .valid_o (mat_vld),
    .m_o     (mat_m)
  );

  assign out_o.valid = mat_vld;
  assign out_o.m00 = mat_m[0];
  assign out_o.m01 = mat_m[1];
  assign out_o.m02 = mat_m[2];
  assign out_o.m10 = mat_m[3];
  assign out_o.m11 = mat_m[4];
  assign out_o.m12 = mat_m[5];
  assign out_o.m20 = mat_m[6];
  assign out_o.m21 = mat_m[7];
  assign out_o.m22 = mat_m[8];

`ifndef ASSERT_OFF
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with empty output slot");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.m22 <= 16'sd16384) && (out_o.m22 >= -16'sd16384)
                 && (out_o.m02 <= 16'sd16384) && (out_o.m02 >= -16'sd16384))
    else $error("matrix element beyond plus or minus one");

  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_vld[0] |-> (chain[0][0].z < (ZW'(DEG_QUARTER) <<< ANGLE_UP))
                  && (chain[0][1].z < (ZW'(DEG_QUARTER) <<< ANGLE_UP))
                  && (chain[0][2].z < (ZW'(DEG_QUARTER) <<< ANGLE_UP)))
    else $error("angle remainder not below a quarter turn");
`endif

endmodule

>>> src/erm_reduce.sv
`timescale 1ns / 1ps
module erm_reduce import erm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] ang_i [NLANES],
  output logic               valid_o,
  output lanes_t             lanes_o
);

  lanes_t lanes_d, lanes_q;
  logic   valid_q;

  always_comb begin
    logic signed [16:0] a;
    logic [12:0]        rem;
    logic [1:0]         quad;
    lanes_d = lanes_q;
    for (int k = 0; k < NLANES; k++) begin
      a = 17'(ang_i[k]);
      if (a < -17'sd23040) a = a + 17'sd46080;
      else if (a < 0) a = a + 17'sd23040;
      else if (a >= 17'sd23040) a = a - 17'sd23040;
      if (a >= 17'sd17280) begin
        quad = 2'd3;
        rem = 13'(a - 17'sd17280);
      end else if (a >= 17'sd11520) begin
        quad = 2'd2;
        rem = 13'(a - 17'sd11520);
      end else if (a >= 17'sd5760) begin
        quad = 2'd1;
        rem = 13'(a - 17'sd5760);
      end else begin
        quad = 2'd0;
        rem = a[12:0];
      end
      lanes_d[k].x = INV_GAIN;
      lanes_d[k].y = '0;
      lanes_d[k].z = ZW'({rem, {ANGLE_UP{1'b0}}});
      lanes_d[k].quad = quad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

endmodule

>>> src/erm_cordic_cell.sv
`timescale 1ns / 1ps
module erm_cordic_cell import erm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [SHW-1:0]       shamt_i,
  input  logic signed [ZW-1:0] atan_i,
  input  lanes_t               lanes_i,
  output logic                 valid_o,
  output lanes_t               lanes_o
);

  lanes_t lanes_d, lanes_q;
  logic   valid_q;

  always_comb begin
    logic signed [31:0] dx, dy;
    for (int k = 0; k < NLANES; k++) begin
      dx = lanes_i[k].y >>> shamt_i;
      dy = lanes_i[k].x >>> shamt_i;
      lanes_d[k].quad = lanes_i[k].quad;
      if (!lanes_i[k].z[ZW-1]) begin
        lanes_d[k].x = lanes_i[k].x - dx;
        lanes_d[k].y = lanes_i[k].y + dy;
        lanes_d[k].z = lanes_i[k].z - atan_i;
      end else begin
        lanes_d[k].x = lanes_i[k].x + dx;
        lanes_d[k].y = lanes_i[k].y - dy;
        lanes_d[k].z = lanes_i[k].z + atan_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

endmodule

>>> src/erm_matrix.sv
`timescale 1ns / 1ps
module erm_matrix import erm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  lanes_t      lanes_i,
  output logic        valid_o,
  output logic [15:0] m_o [9]
);

  // stage A: sine and cosine placed by quadrant
  logic signed [31:0] c_d [NLANES], s_d [NLANES];
  logic signed [31:0] c_q [NLANES], s_q [NLANES];
  // stage B: first products
  logic signed [31:0] srsp_q, crsp_q, ch_b_q, sh_b_q, sp_b_q;
  logic signed [31:0] cpch_q, cpsh_q, srcp_q, crcp_q, crsh_q, crch_q, srsh_q, srch_q;
  // stage C: elements in Q3.30
  logic signed [32:0] e_d [9], e_q [9];
  logic [15:0]        m_d [9], m_q [9];
  logic [3:0]         vld_q;

  always_comb begin
    for (int k = 0; k < NLANES; k++) begin
      case (lanes_i[k].quad)
        2'd0: begin
          c_d[k] = lanes_i[k].x;
          s_d[k] = lanes_i[k].y;
        end
        2'd1: begin
          c_d[k] = -lanes_i[k].y;
          s_d[k] = lanes_i[k].x;
        end
        2'd2: begin
          c_d[k] = -lanes_i[k].x;
          s_d[k] = -lanes_i[k].y;
        end
        default: begin
          c_d[k] = lanes_i[k].y;
          s_d[k] = -lanes_i[k].x;
        end
      endcase
    end
  end

  always_comb begin
    e_d[0] = 33'(cpch_q);
    e_d[1] = 33'(cpsh_q);
    e_d[2] = -33'(sp_b_q);
    e_d[3] = 33'(mul_q(srsp_q, ch_b_q)) - 33'(crsh_q);
    e_d[4] = 33'(mul_q(srsp_q, sh_b_q)) + 33'(crch_q);
    e_d[5] = 33'(srcp_q);
    e_d[6] = 33'(mul_q(crsp_q, ch_b_q)) + 33'(srsh_q);
    e_d[7] = 33'(mul_q(crsp_q, sh_b_q)) - 33'(srch_q);
    e_d[8] = 33'(crcp_q);
    for (int k = 0; k < 9; k++) begin
      m_d[k] = narrow(e_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // lanes: 0 roll, 1 pitch, 2 heading
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q    <= c_d;
      s_q    <= s_d;
      srsp_q <= mul_q(s_q[0], s_q[1]);
      crsp_q <= mul_q(c_q[0], s_q[1]);
      cpch_q <= mul_q(c_q[1], c_q[2]);
      cpsh_q <= mul_q(c_q[1], s_q[2]);
      srcp_q <= mul_q(s_q[0], c_q[1]);
      crcp_q <= mul_q(c_q[0], c_q[1]);
      crsh_q <= mul_q(c_q[0], s_q[2]);
      crch_q <= mul_q(c_q[0], c_q[2]);
      srsh_q <= mul_q(s_q[0], s_q[2]);
      srch_q <= mul_q(s_q[0], c_q[2]);
      ch_b_q <= c_q[2];
      sh_b_q <= s_q[2];
      sp_b_q <= s_q[1];
      e_q    <= e_d;
      m_q    <= m_d;
    end
  end

  assign valid_o = vld_q[3];
  assign m_o = m_q;

endmodule

>>> verif/erm_in_if.sv
`timescale 1ns / 1ps

>>> verif/euler_rotation_matrix_top_tb.sv
`timescale 1ns / 1ps
module euler_rotation_matrix_top_tb;
  import erm_pkg::*;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] heading;
  } angles_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  erm_in_if  in_i ();
  erm_out_if out_o ();

  euler_rotation_matrix_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  angles_t pending_angles[$];
  logic [143:0] expected_matrices[$];
  int  error_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off_cycles = 0;
  bit  stim_done = 1'b0;
  bit  in_taken = 1'b0;

  // Arithmetic shift right, truncating toward minus infinity.
  function automatic longint shr_floor(longint v, int s);
    if (s <= 0) return v;
    if (s > 62) return (v < 0) ? -64'sd1 : 64'sd0;
    return v >>> s;
  endfunction

  function automatic longint shr_round(longint v, int s);
    if (s <= 0) return v;
    if (s > 62) return 0;
    return shr_floor(v + (64'sd1 <<< (s - 1)), s);
  endfunction

  // Arctangent of 2^-i in units of 2^-24 degree.
  function automatic longint arctan_step(int i);
    longint kk, t1, t3, t5, t7;
    case (i)
      0: return 64'sd754974720;
      1: return 64'sd445687602;
      2: return 64'sd235489088;
      3: return 64'sd119537938;
      default: ;
    endcase
    kk = 64'sd961263669 <<< 20;
    t1 = (i < 60) ? (kk >>> i) : 0;
    t3 = (3 * i < 60) ? (kk >>> (3 * i)) / 3 : 0;
    t5 = (5 * i < 60) ? (kk >>> (5 * i)) / 5 : 0;
    t7 = (7 * i < 60) ? (kk >>> (7 * i)) / 7 : 0;
    return shr_round(t1 - t3 + t5 - t7, 20);
  endfunction

  // Cosine and sine in Q2.30 of an angle in 1/64 degree.
  function automatic void angle_cos_sin(input logic signed [15:0] ang,
                                        output longint c, output longint s);
    longint a, rem, x, y, z, nx, dx, dy, t;
    int quad;
    a = longint'(ang) % 23040;
    if (a < 0) a += 23040;
    quad = int'(a / 5760);
    rem = a % 5760;
    x = 652032874;
    y = 0;
    z = rem <<< 18;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      t = arctan_step(i);
      if (z >= 0) begin
        nx = x - dx; y = y + dy; z = z - t;
      end else begin
        nx = x + dx; y = y - dy; z = z + t;
      end
      x = nx;
    end
    case (quad)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return shr_round(a * b, 30);
  endfunction

  function automatic logic [15:0] to_out(longint v);
    longint one, r;
    one = 64'sd1 <<< OUT_FRAC_BITS;
    r = shr_round(v, 30 - OUT_FRAC_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[15:0];
  endfunction

  function automatic logic [143:0] rotation_matrix(angles_t a);
    longint cr, sr, cp, sp, ch, sh, srsp, crsp;
    longint m [9];
    logic [143:0] packed_m;
    angle_cos_sin(a.roll, cr, sr);
    angle_cos_sin(a.pitch, cp, sp);
    angle_cos_sin(a.heading, ch, sh);
    srsp = q30_mul(sr, sp);
    crsp = q30_mul(cr, sp);
    m[0] = q30_mul(cp, ch);
    m[1] = q30_mul(cp, sh);
    m[2] = -sp;
    m[3] = q30_mul(srsp, ch) - q30_mul(cr, sh);
    m[4] = q30_mul(srsp, sh) + q30_mul(cr, ch);
    m[5] = q30_mul(sr, cp);
    m[6] = q30_mul(crsp, ch) + q30_mul(sr, sh);
    m[7] = q30_mul(crsp, sh) - q30_mul(sr, ch);
    m[8] = q30_mul(cr, cp);
    for (int k = 0; k < 9; k++) packed_m[143 - 16 * k -: 16] = to_out(m[k]);
    return packed_m;
  endfunction

  // Record whether the offered transaction was taken at this edge.
  always @(posedge clk_i) begin
    in_taken <= in_i.valid && in_i.ready;
  end

  // Driver: change inputs at the falling edge; hold an offered transaction
  // until it is taken, then pop the next one or idle at random.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_i.valid       <= 1'b0;
      in_i.roll_deg    <= '0;
      in_i.pitch_deg   <= '0;
      in_i.heading_deg <= '0;
    end else if (!in_i.valid || in_taken) begin
      if (pending_angles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        angles_t a;
        a = pending_angles.pop_front();
        in_i.valid       <= 1'b1;
        in_i.roll_deg    <= a.roll;
        in_i.pitch_deg   <= a.pitch;
        in_i.heading_deg <= a.heading;
      end else begin
        in_i.valid <= 1'b0;
      end
    end
  end

  // Predict at acceptance so the expectation queue stays in input order.
  always @(posedge clk_i) begin
    if (rst_ni && in_i.valid && in_i.ready) begin
      angles_t a;
      a.roll = in_i.roll_deg;
      a.pitch = in_i.pitch_deg;
      a.heading = in_i.heading_deg;
      expected_matrices.push_back(rotation_matrix(a));
    end
  end

  // Receiver backpressure; a long hold-off overrides the random stall.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_o.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_o.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_o.valid && out_o.ready) begin
      logic [143:0] got, want;
      got = {out_o.m00, out_o.m01, out_o.m02, out_o.m10, out_o.m11,
             out_o.m12, out_o.m20, out_o.m21, out_o.m22};
      if (expected_matrices.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = expected_matrices.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (got[143 - 16 * k -: 16] !== want[143 - 16 * k -: 16]) begin
            error_count++;
            $display("%0t: m%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
                     $signed(want[143 - 16 * k -: 16]),
                     $signed(got[143 - 16 * k -: 16]));
          end
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'(($urandom_range(7) * 5760) + $urandom_range(2) - 1
                    - 23040 * $urandom_range(1));
      1: return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(3))
                                  : 16'sh8000 + 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_angles(logic signed [15:0] r, logic signed [15:0] p,
                            logic signed [15:0] h);
    angles_t a;
    a.roll = r;
    a.pitch = p;
    a.heading = h;
    pending_angles.push_back(a);
  endtask

  // Drain the queues, then let the pipeline settle.
  task automatic wait_drained();
    wait (pending_angles.size() == 0 && !in_i.valid);
    wait (expected_matrices.size() == 0);
    repeat (30) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero, field extremes, quadrant edges, negatives, one-LSB.
    add_angles(0, 0, 0);
    add_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
    add_angles(16'sh8000, 16'sh8000, 16'sh8000);
    add_angles(5760, 0, 0);
    add_angles(0, 5760, 0);
    add_angles(0, 0, 5760);
    add_angles(11520, 11520, 11520);
    add_angles(17280, 17280, 17280);
    add_angles(-5760, -11520, -17280);
    add_angles(5759, 5761, -1);
    add_angles(1, -1, 23040);
    add_angles(-23040, 23039, -23041);
    add_angles(2880, -2880, 1920);
    add_angles(16'sh5555, 16'shaaaa, 16'sh0f0f);
    add_angles(16'shaaaa, 16'sh5555, 16'shf0f0);
    wait_drained();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 78 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? 78 : 0;
      if (ph == 3) begin
        send_idle_pct = 9;
        recv_stall_pct = 9;
      end
      for (int n = 0; n < 360; n++) add_angles(rand_angle(), rand_angle(), rand_angle());
      if (ph == 0) begin
        // Long receiver hold-off while the sender keeps offering.
        repeat (20) @(posedge clk_i);
        @(negedge clk_i);
        hold_off_cycles = 200;
      end
      wait_drained();
    end
    stim_done = 1'b1;
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
